>>> design/gps_pkg.sv
// shared constants, types and bit map helpers for the goldbach prime split block
`timescale 1ns / 1ps

package gps_pkg;

  // field widths
  localparam int NUM_W   = 17;
  localparam int SMALL_W = 16;

  // sieve bound and bit map geometry: one flag per odd number, 64 flags a word
  localparam logic [NUM_W-1:0] LIMIT     = 17'd65536;
  localparam int               WORD_W    = 64;
  localparam int               BIT_W     = 6;
  localparam int               MAP_DEPTH = 512;
  localparam int               MAP_AW    = 9;

  // sieve primes run over odd p with p * p <= LIMIT
  localparam int               P_W     = 8;
  localparam logic [P_W-1:0]   P_FIRST = 8'd3;
  localparam logic [P_W-1:0]   P_LAST  = 8'd255;

  // small-number rules and the lowest odd candidate
  localparam logic [NUM_W-1:0]   SMALL_MAX  = 17'd6;
  localparam logic [NUM_W-1:0]   ONLY_SMALL = 17'd5;
  localparam logic [NUM_W-1:0]   PRIME_TWO  = 17'd2;
  localparam logic [NUM_W-1:0]   PRIME_THREE = 17'd3;
  localparam logic [SMALL_W-1:0] T_LAST     = 16'd3;

  // one access to the bit map
  typedef struct packed {
    logic              we;
    logic [MAP_AW-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } map_req_t;

  // word that holds the flag of odd x
  function automatic logic [MAP_AW-1:0] map_addr(input logic [NUM_W-1:0] x);
    return x[MAP_AW+6:7];
  endfunction

  // bit within that word
  function automatic logic [BIT_W-1:0] map_bit(input logic [NUM_W-1:0] x);
    return x[BIT_W:1];
  endfunction

endpackage

>>> design/gps_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps

module gps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and read the addressed word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/gps_sieve.sv
// clears the bit map and marks odd composites with a sieve of eratosthenes
`timescale 1ns / 1ps

module gps_sieve import gps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [WORD_W-1:0] rdata,
  output map_req_t          req,
  output logic              ready
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_P_RD,
    S_P_CHK,
    S_M_RD,
    S_M_WR,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [MAP_AW-1:0] clr_r, clr_nxt;
  logic [P_W-1:0]    p_r, p_nxt;
  logic [NUM_W-1:0]  m_r, m_nxt;
  logic              ready_r, ready_nxt;

  logic [2*P_W-1:0]  p_sq;
  logic [NUM_W-1:0]  m_sum;
  logic [NUM_W-1:0]  p_ext;

  // square of the current prime and the next multiple
  assign p_ext = {{(NUM_W-P_W){1'b0}}, p_r};
  assign p_sq  = {{P_W{1'b0}}, p_r} * {{P_W{1'b0}}, p_r};
  assign m_sum = m_r + {p_ext[NUM_W-2:0], 1'b0};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    p_nxt     = p_r;
    m_nxt     = m_r;
    ready_nxt = ready_r;
    req.we    = 1'b0;
    req.addr  = '0;
    req.wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        req.we   = 1'b1;
        req.addr = clr_r;
        clr_nxt  = clr_r + MAP_AW'(1);
        if (clr_r == MAP_AW'(MAP_DEPTH - 1)) begin
          p_nxt     = P_FIRST;
          state_nxt = S_P_RD;
        end
      end
      S_P_RD: begin
        req.addr  = map_addr(p_ext);
        state_nxt = S_P_CHK;
      end
      S_P_CHK: begin
        if (!rdata[map_bit(p_ext)]) begin
          m_nxt     = {1'b0, p_sq};
          state_nxt = S_M_RD;
        end else if (p_r == P_LAST) begin
          state_nxt = S_DONE;
        end else begin
          p_nxt     = p_r + P_W'(2);
          state_nxt = S_P_RD;
        end
      end
      S_M_RD: begin
        req.addr  = map_addr(m_r);
        state_nxt = S_M_WR;
      end
      S_M_WR: begin
        // read-modify-write of one composite flag
        req.we    = 1'b1;
        req.addr  = map_addr(m_r);
        req.wdata = rdata | (WORD_W'(1) << map_bit(m_r));
        m_nxt     = m_sum;
        if (m_sum <= LIMIT) begin
          state_nxt = S_M_RD;
        end else if (p_r == P_LAST) begin
          state_nxt = S_DONE;
        end else begin
          p_nxt     = p_r + P_W'(2);
          state_nxt = S_P_RD;
        end
      end
      S_DONE: begin
        ready_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // state and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ready_r <= ready_nxt;
    end
    p_r <= p_nxt;
    m_r <= m_nxt;
  end

  assign ready = ready_r;

endmodule

>>> design/gps_search.sv
// per-word sequencer that finds the prime pair using bit map lookups
`timescale 1ns / 1ps

module gps_search import gps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W-1:0]   number,
  input  logic [WORD_W-1:0]  rdata,
  output logic [MAP_AW-1:0]  rd_addr,
  output logic               busy,
  output logic               out_valid,
  output logic               out_found,
  output logic [SMALL_W-1:0] out_smaller,
  output logic [NUM_W-1:0]   out_larger
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_T_CHK,
    S_U_CHK,
    S_O_CHK
  } state_t;

  state_t             state_r, state_nxt;
  logic [NUM_W-1:0]   n_r, n_nxt;
  logic [SMALL_W-1:0] t_r, t_nxt;
  logic [NUM_W-1:0]   u_r, u_nxt;
  logic               valid_r, valid_nxt;
  logic               found_r, found_nxt;
  logic [SMALL_W-1:0] small_r, small_nxt;
  logic [NUM_W-1:0]   large_r, large_nxt;

  logic [SMALL_W-1:0] half;
  logic [SMALL_W-1:0] t_first;
  logic [SMALL_W-1:0] t_down;
  logic [NUM_W-1:0]   t_ext;
  logic [NUM_W-1:0]   u_calc;
  logic [NUM_W-1:0]   odd_u;
  logic               t_prime;
  logic               u_prime;

  // candidate arithmetic: largest odd t below n / 2, then steps of two
  assign half    = number[NUM_W-1:1];
  assign t_first = half[0] ? half - SMALL_W'(2) : half - SMALL_W'(1);
  assign t_down  = t_r - SMALL_W'(2);
  assign t_ext   = {1'b0, t_r};
  assign u_calc  = n_r - t_ext;
  assign odd_u   = number - PRIME_TWO;
  assign t_prime = !rdata[map_bit(t_ext)];
  assign u_prime = !rdata[map_bit(u_r)];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    t_nxt     = t_r;
    u_nxt     = u_r;
    valid_nxt = 1'b0;
    found_nxt = found_r;
    small_nxt = small_r;
    large_nxt = large_r;
    rd_addr   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          n_nxt = number;
          if (number <= SMALL_MAX) begin
            valid_nxt = 1'b1;
            found_nxt = (number == ONLY_SMALL);
            small_nxt = (number == ONLY_SMALL) ? PRIME_TWO[SMALL_W-1:0] : '0;
            large_nxt = (number == ONLY_SMALL) ? PRIME_THREE : '0;
          end else if (number[0]) begin
            // odd: only the pair with two is possible
            if (odd_u > LIMIT) begin
              valid_nxt = 1'b1;
              found_nxt = 1'b0;
              small_nxt = '0;
              large_nxt = '0;
            end else begin
              u_nxt     = odd_u;
              rd_addr   = map_addr(odd_u);
              state_nxt = S_O_CHK;
            end
          end else begin
            t_nxt     = t_first;
            rd_addr   = map_addr({1'b0, t_first});
            state_nxt = S_T_CHK;
          end
        end
      end
      S_T_CHK: begin
        if (t_prime && (u_calc <= LIMIT)) begin
          u_nxt     = u_calc;
          rd_addr   = map_addr(u_calc);
          state_nxt = S_U_CHK;
        end else if (t_r == T_LAST) begin
          valid_nxt = 1'b1;
          found_nxt = 1'b0;
          small_nxt = '0;
          large_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          t_nxt   = t_down;
          rd_addr = map_addr({1'b0, t_down});
        end
      end
      S_U_CHK: begin
        if (u_prime) begin
          valid_nxt = 1'b1;
          found_nxt = 1'b1;
          small_nxt = t_r;
          large_nxt = u_r;
          state_nxt = S_IDLE;
        end else if (t_r == T_LAST) begin
          valid_nxt = 1'b1;
          found_nxt = 1'b0;
          small_nxt = '0;
          large_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          t_nxt     = t_down;
          rd_addr   = map_addr({1'b0, t_down});
          state_nxt = S_T_CHK;
        end
      end
      S_O_CHK: begin
        valid_nxt = 1'b1;
        found_nxt = u_prime;
        small_nxt = u_prime ? PRIME_TWO[SMALL_W-1:0] : '0;
        large_nxt = u_prime ? u_r : '0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    n_r     <= n_nxt;
    t_r     <= t_nxt;
    u_r     <= u_nxt;
    found_r <= found_nxt;
    small_r <= small_nxt;
    large_r <= large_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = valid_r;
  assign out_found   = found_r;
  assign out_smaller = small_r;
  assign out_larger  = large_r;

endmodule

>>> design/goldbach_prime_split_top.sv
// top level of the goldbach prime split block: sieve, search and bit map ram
`timescale 1ns / 1ps

// After reset the block clears its 512-word bit map of odd composites and then sieves it up
// to 65536, checking each odd p and marking each multiple with a read and a write on the
// single ram port; busy stays high until then. A word is taken when start is high and busy
// low. Numbers up to six give their result in the cycle after the word is taken and leave
// busy low, as do odd numbers whose partner n - 2 lies past the sieve; other odd numbers
// take one map lookup. Even numbers walk down over odd candidates from n / 2: each candidate
// takes one map lookup, and each prime candidate whose partner lies within the sieve a second
// for the partner; the result is registered, so the time varies with the gap to the pair.
// out_valid is high for exactly one cycle per word and cannot be held off.
module goldbach_prime_split_top import gps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [NUM_W-1:0]   in_number,
  output logic               out_valid,
  output logic               out_found,
  output logic [SMALL_W-1:0] out_smaller_prime,
  output logic [NUM_W-1:0]   out_larger_prime
);

  map_req_t          sieve_req;
  map_req_t          ram_req;
  logic              sieve_ready;
  logic [WORD_W-1:0] rdata;
  logic [MAP_AW-1:0] search_addr;
  logic              search_busy;

  // bit map builder
  gps_sieve u_sieve (
    .clk   (clk),
    .rst_n (rst_n),
    .rdata (rdata),
    .req   (sieve_req),
    .ready (sieve_ready)
  );

  // query sequencer
  gps_search u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start && !busy),
    .number      (in_number),
    .rdata       (rdata),
    .rd_addr     (search_addr),
    .busy        (search_busy),
    .out_valid   (out_valid),
    .out_found   (out_found),
    .out_smaller (out_smaller_prime),
    .out_larger  (out_larger_prime)
  );

  // ram port goes to the sieve until the map is built
  always_comb begin
    if (sieve_ready) begin
      ram_req.we    = 1'b0;
      ram_req.addr  = search_addr;
      ram_req.wdata = '0;
    end else begin
      ram_req = sieve_req;
    end
  end

  gps_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (rdata)
  );

  assign busy = !sieve_ready || search_busy;

endmodule
